// ----- rtl/max_flow_augmenting_paths_top_defines.svh -----
// assertion macros for the max flow block
`ifndef MAX_FLOW_AUGMENTING_PATHS_TOP_DEFINES_SVH
`define MAX_FLOW_AUGMENTING_PATHS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MFAP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mfap assertion failed");
`define MFAP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mfap assertion failed");
`else
`define MFAP_ASSERT(lbl, clk, rst_n, prop)
`define MFAP_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ----- rtl/mfap_pkg.sv -----
// package with sizes, codes and state type of the max flow block
package mfap_pkg;
  localparam int MAX_NODES  = 64;
  localparam int NODE_BITS  = 6;
  localparam int CAP_BITS   = 16;
  localparam int CELL_BITS  = CAP_BITS + 1;
  localparam int FLOW_BITS  = 22;
  localparam int ADDR_BITS  = 2 * NODE_BITS;
  localparam int CNT_BITS   = NODE_BITS + 1;
  localparam logic [FLOW_BITS-1:0] FLOW_MAX = {FLOW_BITS{1'b1}};
  localparam logic [CELL_BITS-1:0] CELL_MAX = {CELL_BITS{1'b1}};

  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_SOURCE     = 2'd1;
  localparam logic [1:0] CFG_SINK       = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_BFS_INIT, ST_POP, ST_POP_WAIT, ST_SCAN, ST_SCAN_END,
    ST_WALK_P, ST_WALK_M, ST_WALK_C, ST_UPD_P, ST_UPD_R, ST_UPD_F, ST_UPD_W,
    ST_FLOW_ADD, ST_FINISH
  } state_e;
endpackage

// ----- rtl/mfap_ram.sv -----
// generic simple dual port ram with registered read
module mfap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/max_flow_augmenting_paths_top.sv -----
// max flow: edge capacity loads and breadth-first augmenting path search
// reset: residual matrix cleared by a pass over all 4096 entries, no item taken meanwhile
// load request: loads can follow each other every cycle while the block is idle
// run request: per round a breadth-first search, paced by the one matrix read
// port, then a walk back along the path to find the bottleneck and a second
// walk to update the residuals, plus a final search; the result is registered after that
`include "max_flow_augmenting_paths_top_defines.svh"
module max_flow_augmenting_paths_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // from_node[5:0], to_node[11:6], edge_capacity[27:12]
  input  logic        s_axis_tuser,  // op
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // max_flow[21:0]
  output logic        m_axis_tuser   // error_flag
);
  import mfap_pkg::*;

  state_e                state_q, state_d;
  logic [ADDR_BITS-1:0]  clr_q, clr_d;
  logic [NODE_BITS-1:0]  node_count_q, source_q, sink_q;
  logic [MAX_NODES-1:0]  visited_q, visited_d;
  logic [CNT_BITS-1:0]   head_q, head_d, tail_q, tail_d;
  logic [NODE_BITS-1:0]  u_q, u_d, v_q, v_d, pv_q, pv_d;
  logic                  pvalid_q, pvalid_d;
  logic [CELL_BITS-1:0]  neck_q, neck_d;
  logic [FLOW_BITS-1:0]  total_q, total_d;
  logic                  err_q, err_d;
  logic                  out_valid_q, out_valid_d;
  logic [FLOW_BITS-1:0]  out_flow_q, out_flow_d;
  logic                  out_err_q, out_err_d;

  // memory ports
  logic                  m_we;
  logic [ADDR_BITS-1:0]  m_waddr, m_raddr;
  logic [CELL_BITS-1:0]  m_wdata, m_rdata;
  logic                  q_we;
  logic [NODE_BITS-1:0]  q_waddr, q_wdata, q_raddr, q_rdata;
  logic                  p_we;
  logic [NODE_BITS-1:0]  p_waddr, p_wdata, p_raddr, p_rdata;

  logic                  in_acc;
  logic [NODE_BITS-1:0]  in_from, in_to;
  logic [CAP_BITS-1:0]   in_cap;
  logic                  hit;
  logic [CELL_BITS:0]    back_sum;
  logic [FLOW_BITS:0]    flow_sum;

  assign in_from = s_axis_tdata[5:0];
  assign in_to   = s_axis_tdata[11:6];
  assign in_cap  = s_axis_tdata[27:12];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_flow_q};
  assign m_axis_tuser  = out_err_q;

  // residual matrix, search queue and parent links
  mfap_ram #(.WIDTH(CELL_BITS), .DEPTH(MAX_NODES * MAX_NODES)) u_matrix (
    .clk_i(clk_i), .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );
  mfap_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_queue (
    .clk_i(clk_i), .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );
  mfap_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_parent (
    .clk_i(clk_i), .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 6'd63;
      source_q     <= 6'd1;
      sink_q       <= 6'd2;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NODE_COUNT: node_count_q <= cfg_data_i;
        CFG_SOURCE:     source_q     <= cfg_data_i;
        CFG_SINK:       sink_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      visited_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      pvalid_q    <= 1'b0;
      total_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      visited_q   <= visited_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      pvalid_q    <= pvalid_d;
      total_q     <= total_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q        <= u_d;
    v_q        <= v_d;
    pv_q       <= pv_d;
    neck_q     <= neck_d;
    out_flow_q <= out_flow_d;
    out_err_q  <= out_err_d;
  end

  // scan hit, reverse residual and flow sums
  assign hit = pvalid_q && !visited_q[pv_q] && (m_rdata != '0) &&
               (tail_q < CNT_BITS'(MAX_NODES));
  assign back_sum = {1'b0, m_rdata} + {1'b0, neck_q};
  assign flow_sum = {1'b0, total_q} + (FLOW_BITS+1)'(neck_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    visited_d   = visited_q;
    head_d      = head_q;
    tail_d      = tail_q;
    u_d         = u_q;
    v_d         = v_q;
    pv_d        = v_q;
    pvalid_d    = 1'b0;
    neck_d      = neck_q;
    total_d     = total_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_flow_d  = out_flow_q;
    out_err_d   = out_err_q;
    m_we        = 1'b0;
    m_waddr     = {u_q, v_q};
    m_wdata     = '0;
    m_raddr     = {u_q, v_q};
    q_we        = 1'b0;
    q_waddr     = tail_q[NODE_BITS-1:0];
    q_wdata     = pv_q;
    q_raddr     = head_q[NODE_BITS-1:0];
    p_we        = 1'b0;
    p_waddr     = pv_q;
    p_wdata     = u_q;
    p_raddr     = v_q;

    // scan pipeline: one matrix entry checked per cycle
    if (hit) begin
      q_we = 1'b1;
      p_we = 1'b1;
      visited_d[pv_q] = 1'b1;
      tail_d = tail_q + 1'b1;
    end

    unique case (state_q)
      ST_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == {ADDR_BITS{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == OP_LOAD) begin
            m_we    = 1'b1;
            m_waddr = {in_from, in_to};
            m_wdata = {1'b0, in_cap};
          end else begin
            total_d = '0;
            if (source_q == sink_q) begin
              err_d   = 1'b1;
              state_d = ST_FINISH;
            end else begin
              err_d   = 1'b0;
              state_d = ST_BFS_INIT;
            end
          end
        end
      end
      ST_BFS_INIT: begin
        visited_d = '0;
        visited_d[source_q] = 1'b1;
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = source_q;
        p_we    = 1'b1;
        p_waddr = source_q;
        p_wdata = source_q;
        head_d  = '0;
        tail_d  = CNT_BITS'(1);
        state_d = ST_POP;
      end
      ST_POP: begin
        if (head_q < tail_q) begin
          head_d  = head_q + 1'b1;
          state_d = ST_POP_WAIT;
        end else if (visited_q[sink_q]) begin
          v_d     = sink_q;
          neck_d  = CELL_MAX;
          state_d = ST_WALK_P;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_POP_WAIT: begin
        u_d = q_rdata;
        v_d = NODE_BITS'(1);
        state_d = (node_count_q == '0) ? ST_POP : ST_SCAN;
      end
      ST_SCAN: begin
        pvalid_d = 1'b1;
        if (v_q == node_count_q) begin
          state_d = ST_SCAN_END;
        end else begin
          v_d = v_q + 1'b1;
        end
      end
      ST_SCAN_END: begin
        state_d = ST_POP;
      end
      ST_WALK_P: begin
        state_d = ST_WALK_M;
      end
      ST_WALK_M: begin
        u_d     = p_rdata;
        m_raddr = {p_rdata, v_q};
        state_d = ST_WALK_C;
      end
      ST_WALK_C: begin
        if (m_rdata < neck_q) begin
          neck_d = m_rdata;
        end
        if (u_q == source_q) begin
          v_d     = sink_q;
          state_d = ST_UPD_P;
        end else begin
          v_d     = u_q;
          state_d = ST_WALK_P;
        end
      end
      ST_UPD_P: begin
        state_d = ST_UPD_R;
      end
      ST_UPD_R: begin
        u_d     = p_rdata;
        m_raddr = {v_q, p_rdata};
        state_d = ST_UPD_F;
      end
      ST_UPD_F: begin
        m_we    = 1'b1;
        m_waddr = {v_q, u_q};
        m_wdata = back_sum[CELL_BITS] ? CELL_MAX : back_sum[CELL_BITS-1:0];
        m_raddr = {u_q, v_q};
        state_d = ST_UPD_W;
      end
      ST_UPD_W: begin
        m_we    = 1'b1;
        m_waddr = {u_q, v_q};
        m_wdata = m_rdata - neck_q;
        v_d     = u_q;
        state_d = (u_q == source_q) ? ST_FLOW_ADD : ST_UPD_P;
      end
      ST_FLOW_ADD: begin
        total_d = (flow_sum > {1'b0, FLOW_MAX}) ? FLOW_MAX : flow_sum[FLOW_BITS-1:0];
        state_d = ST_BFS_INIT;
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_flow_d  = total_q;
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `MFAP_ASSERT(a_tail_bound, clk_i, rst_ni, tail_q <= CNT_BITS'(MAX_NODES))
  `MFAP_ASSERT(a_head_tail, clk_i, rst_ni, (state_q != ST_POP) || (head_q <= tail_q))
  `MFAP_ASSERT(a_clear_busy, clk_i, rst_ni, (state_q != ST_CLEAR) || !s_axis_tready)
  `MFAP_ASSERT(a_err_zero, clk_i, rst_ni, !(out_valid_q && out_err_q) || (out_flow_q == '0))
  `MFAP_ASSERT_NEXT(a_scan_pipe, clk_i, rst_ni, state_q == ST_SCAN, pvalid_q)
endmodule
